// File: sv/bitmap_first_free_allocator_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap first-free allocator
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BFFA_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bffa assertion failed");

// next-cycle implication, disabled while reset is asserted
`define BFFA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bffa assertion failed");

`endif

// File: sv/bffa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bffa_pkg
// Types, codes and helpers shared by the allocator and its checker.
// ---------------------------------------------------------------------------
package bffa_pkg;

  typedef logic [1:0] act_t;

  localparam act_t ACT_LOAD  = 2'd0;
  localparam act_t ACT_FIND  = 2'd1;
  localparam act_t ACT_CLAIM = 2'd2;

  localparam int CFG_LEN_W  = 11;
  localparam int BYTE_IDX_W = 10;
  localparam int FREE_IDX_W = 14;

  typedef logic [CFG_LEN_W-1:0]  len_t;
  typedef logic [FREE_IDX_W-1:0] free_idx_t;

  // register index is paddr[2]
  localparam logic REG_BYTES_IN_USE = 1'b0;
  localparam logic REG_INDEX_BASE   = 1'b1;

  localparam len_t BYTES_IN_USE_RST = 11'd1024;

  // position of the lowest clear bit; only meaningful when b != 8'hFF
  function automatic logic [2:0] first_zero(input logic [7:0] b);
    logic [2:0] pos;
    pos = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (!b[j]) pos = 3'(j);
    end
    return pos;
  endfunction

endpackage

// File: sv/bitmap_first_free_allocator_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bitmap_first_free_allocator_unit
// First-fit allocator over a byte-wide usage bitmap held in on-chip memory.
// ---------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------
//  in      | in_valid / in_ready    | in_action, in_byte_index, in_byte_value
//  out     | out_valid / out_ready  | out_found, out_free_index
//  cfg     | APB, cfg_pready tied 1 | cfg_paddr, cfg_pwdata, cfg_prdata
//
// A find or claim reads the bitmap memory one byte per cycle through its
// single read port, stopping at the first byte that holds a free bit or
// after L bytes when none is free, where L is bytes_in_use clipped to
// BITMAP_BYTES.
// The input side is ready only while the sequencer is idle. A finished item
// waits in the output register; a second result waits in a hold stage.
// Reset is synchronous; the bitmap memory is not cleared and must be loaded.
// ---------------------------------------------------------------------------
module bitmap_first_free_allocator_unit #(
  parameter int BITMAP_BYTES = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bffa_pkg::act_t                   in_action,
  input  logic [bffa_pkg::BYTE_IDX_W-1:0]  in_byte_index,
  input  logic [7:0]                       in_byte_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_found,
  output bffa_pkg::free_idx_t              out_free_index,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [2:0]                       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import bffa_pkg::*;

  localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]  state_r, state_nxt;
  len_t        cnt_r, cnt_nxt;
  len_t        limit_r, limit_nxt;
  logic        claim_r, claim_nxt;
  logic        rd_vld_r, rd_vld_nxt;
  len_t        rd_idx_r, rd_idx_nxt;
  logic [7:0]  rd_data_r;
  logic        hold_found_r, hold_found_nxt;
  free_idx_t   hold_idx_r, hold_idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_found_r, out_found_nxt;
  free_idx_t   out_idx_r, out_idx_nxt;
  len_t        cfg_len_r;
  logic        cfg_base_r;

  logic [7:0]  mem [BITMAP_BYTES];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  logic        in_fire, slot_free, cfg_wr, hit;
  logic [2:0]  bit_pos;
  free_idx_t   hit_idx;
  len_t        limit_now;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign slot_free  = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_free_index = out_idx_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_INDEX_BASE) ? {31'd0, cfg_base_r}
                                                       : {21'd0, cfg_len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r  <= BYTES_IN_USE_RST;
      cfg_base_r <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_BYTES_IN_USE) cfg_len_r <= cfg_pwdata[CFG_LEN_W-1:0];
      else                                  cfg_base_r <= cfg_pwdata[0];
    end
  end

  // scan length clipped to the bitmap size
  assign limit_now = (32'(cfg_len_r) > BITMAP_BYTES) ? len_t'(BITMAP_BYTES) : cfg_len_r;

  assign hit     = rd_vld_r && (rd_data_r != 8'hFF);
  assign bit_pos = first_zero(rd_data_r);
  assign hit_idx = free_idx_t'({rd_idx_r, 3'b000}) + free_idx_t'(bit_pos)
                 + free_idx_t'(cfg_base_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    limit_nxt      = limit_r;
    claim_nxt      = claim_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    hold_found_nxt = hold_found_r;
    hold_idx_nxt   = hold_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_found_nxt  = out_found_r;
    out_idx_nxt    = out_idx_r;
    mem_we         = 1'b0;
    mem_waddr      = AW'(in_byte_index);
    mem_wdata      = in_byte_value;
    mem_re         = 1'b0;
    mem_raddr      = AW'(cnt_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_action == ACT_FIND || in_action == ACT_CLAIM) begin
            state_nxt = ST_SCAN;
            cnt_nxt   = '0;
            limit_nxt = limit_now;
            claim_nxt = (in_action == ACT_CLAIM);
          end else begin
            // loads and the unused code answer not-found at once
            mem_we = (in_action == ACT_LOAD) && (32'(in_byte_index) < BITMAP_BYTES);
            if (slot_free) begin
              out_valid_nxt = 1'b1;
              out_found_nxt = 1'b0;
              out_idx_nxt   = '0;
            end else begin
              state_nxt      = ST_HOLD;
              hold_found_nxt = 1'b0;
              hold_idx_nxt   = '0;
            end
          end
        end
      end
      ST_SCAN: begin
        if (hit || cnt_r >= limit_r) begin
          if (hit && claim_r) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(rd_idx_r);
            mem_wdata = rd_data_r | (8'd1 << bit_pos);
          end
          if (slot_free) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_found_nxt = hit;
            out_idx_nxt   = hit ? hit_idx : '0;
          end else begin
            state_nxt      = ST_HOLD;
            hold_found_nxt = hit;
            hold_idx_nxt   = hit ? hit_idx : '0;
          end
        end else begin
          // keep one read in flight: data for byte cnt arrives next cycle
          mem_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r;
          cnt_nxt    = cnt_r + len_t'(1);
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_found_nxt = hold_found_r;
          out_idx_nxt   = hold_idx_r;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    limit_r      <= limit_nxt;
    claim_r      <= claim_nxt;
    rd_idx_r     <= rd_idx_nxt;
    hold_found_r <= hold_found_nxt;
    hold_idx_r   <= hold_idx_nxt;
    out_found_r  <= out_found_nxt;
    out_idx_r    <= out_idx_nxt;
  end

endmodule

// File: sv/bffa_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bffa_checker
// Port-level checks for the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "bitmap_first_free_allocator_unit_macros.svh"

module bffa_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input bffa_pkg::act_t       in_action,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_found,
  input bffa_pkg::free_idx_t  out_free_index
);
  import bffa_pkg::*;

  // a waiting result must not change
  `BFFA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_free_index))

  // a miss always reports index zero
  `BFFA_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !out_found, out_free_index == '0)

  // a scan request occupies the sequencer for at least the next cycle
  `BFFA_ASSERT_NEXT(a_scan_busy, clk, rst_n, in_valid && in_ready && (in_action == ACT_FIND || in_action == ACT_CLAIM), !in_ready)

endmodule

bind bitmap_first_free_allocator_unit bffa_checker u_bffa_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit bitmap allocator. Directed loads and
// scans come first, then random traffic over several bitmap lengths and index
// bases, with a deep miss-then-hit pass at the end. A scoreboard predicts each
// result and checks it as it comes out of the block.
// ---------------------------------------------------------------------------
module tb_top;
  import bffa_pkg::*;

  localparam int BITMAP_BYTES = 1024;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DEEP_BYTES   = 48;
  localparam act_t ACT_NONE   = 2'd3;

  typedef struct packed {
    logic      found;
    free_idx_t free_index;
  } alloc_res_t;

  // predicts each allocator response and checks it in arrival order
  class alloc_scoreboard;
    logic [7:0]  bitmap [BITMAP_BYTES];
    bit          loaded [BITMAP_BYTES];
    int unsigned scan_len;
    logic        base;
    alloc_res_t  expected [$];
    int          errors;

    function new();
      scan_len = 32'(BYTES_IN_USE_RST);
      base     = 1'b0;
      errors   = 0;
    endfunction

    function void set_reg(logic sel, logic [31:0] data);
      if (sel == REG_BYTES_IN_USE) scan_len = 32'(data[CFG_LEN_W-1:0]);
      else base = data[0];
    endfunction

    function int scan_limit();
      return (scan_len > BITMAP_BYTES) ? BITMAP_BYTES : scan_len;
    endfunction

    // a byte the next scan could read before it is loaded, or -1;
    // also guards the byte after the hit in case the block reads ahead
    function int first_unread();
      int eff;
      eff = scan_limit();
      for (int i = 0; i < eff; i++) begin
        if (!loaded[i]) return i;
        if (bitmap[i] != 8'hFF) begin
          if (i + 1 < eff && !loaded[i+1]) return i + 1;
          return -1;
        end
      end
      return -1;
    endfunction

    function void note_item(act_t act, logic [9:0] idx, logic [7:0] val);
      alloc_res_t res;
      int         eff;
      bit         hit;
      res = '0;
      hit = 1'b0;
      if (act == ACT_LOAD) begin
        bitmap[idx] = val;
        loaded[idx] = 1'b1;
      end else if (act == ACT_FIND || act == ACT_CLAIM) begin
        eff = scan_limit();
        for (int i = 0; i < eff && !hit; i++) begin
          for (int j = 0; j < 8 && !hit; j++) begin
            if (!bitmap[i][j]) begin
              hit = 1'b1;
              res.found = 1'b1;
              res.free_index = free_idx_t'(i * 8 + j + int'(base));
              if (act == ACT_CLAIM) bitmap[i][j] = 1'b1;
            end
          end
        end
      end
      expected.push_back(res);
    endfunction

    function void check_result(logic found, free_idx_t free_index);
      alloc_res_t want;
      if (expected.size() == 0) begin
        $error("unexpected result: found %0d free_index %0d", found, free_index);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, found);
        errors++;
      end
      if (free_index !== want.free_index) begin
        $error("free_index: expected %0d, got %0d", want.free_index, free_index);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  act_t        in_action;
  logic [9:0]  in_byte_index;
  logic [7:0]  in_byte_value;
  logic        out_valid;
  logic        out_ready;
  logic        out_found;
  free_idx_t   out_free_index;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  alloc_scoreboard alloc_sb = new();
  bit calm;     // no idling on either side
  bit squeeze;  // receiver holds off once
  bit squeezed;
  int quiet_cycles;

  bitmap_first_free_allocator_unit #(.BITMAP_BYTES(BITMAP_BYTES)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_byte_index  (in_byte_index),
    .in_byte_value  (in_byte_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_free_index (out_free_index),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // leans toward full bytes and single-hole bytes so scans go deep
  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'hFF;
    if (r < 7) return ~(8'd1 << $urandom_range(0, 7));
    return 8'($urandom);
  endfunction

  task automatic push_item(input act_t act, input logic [9:0] idx, input logic [7:0] val);
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_byte_index <= idx;
    in_byte_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    alloc_sb.note_item(act, idx, val);
  endtask

  // find or claim, but first load any byte the scan would touch unloaded
  task automatic push_request(input act_t act);
    int gap;
    gap = alloc_sb.first_unread();
    if (gap >= 0) push_item(ACT_LOAD, 10'(gap), rand_byte());
    else push_item(act, 10'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (alloc_sb.expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    alloc_sb.set_reg(sel, data);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits carry noise; the block keeps only the register width
  task automatic set_regs(input len_t len, input logic base);
    drain();
    write_reg(REG_BYTES_IN_USE, {21'($urandom), len});
    write_reg(REG_INDEX_BASE, {31'($urandom), base});
  endtask

  task automatic random_burst(input int n_items);
    int pick;
    int span;
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      span = alloc_sb.scan_limit();
      if (span == 0) span = 16;
      if (pick < 35) begin
        if ($urandom_range(0, 9) == 0)
          push_item(ACT_LOAD, 10'($urandom), rand_byte());
        else
          push_item(ACT_LOAD, 10'($urandom_range(0, span - 1)), rand_byte());
      end else if (pick < 60) begin
        push_request(ACT_FIND);
      end else if (pick < 95) begin
        push_request(ACT_CLAIM);
      end else begin
        push_item(ACT_NONE, 10'($urandom), 8'($urandom));
      end
    end
  endtask

  // receiver
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 29);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) alloc_sb.check_result(out_found, out_free_index);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_action     <= ACT_LOAD;
    in_byte_index <= '0;
    in_byte_value <= '0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: hole in the last bit, full bitmap, unused action, base, empty scan
    set_regs(11'd2, 1'b0);
    push_item(ACT_LOAD, 10'd0, 8'hFF);
    push_item(ACT_LOAD, 10'd1, 8'h7F);
    push_item(ACT_FIND, 10'd1023, 8'hFF);
    push_item(ACT_CLAIM, 10'd0, 8'h00);
    push_item(ACT_FIND, 10'd0, 8'h00);
    push_item(ACT_CLAIM, 10'd0, 8'h00);
    push_item(ACT_LOAD, 10'd1023, 8'h00);
    push_item(ACT_NONE, 10'd1023, 8'hFF);
    push_item(ACT_LOAD, 10'd0, 8'h00);
    push_item(ACT_CLAIM, 10'd0, 8'h00);
    push_item(ACT_CLAIM, 10'd0, 8'h00);
    push_item(ACT_FIND, 10'd0, 8'h00);
    set_regs(11'd2, 1'b1);
    push_item(ACT_FIND, 10'd0, 8'h00);
    set_regs(11'd0, 1'b1);
    push_item(ACT_CLAIM, 10'd0, 8'h00);
    push_item(ACT_FIND, 10'd0, 8'h00);
    set_regs(11'd1, 1'b1);
    push_item(ACT_LOAD, 10'd0, 8'h7F);
    push_item(ACT_FIND, 10'd0, 8'h00);

    set_regs(11'd4, 1'b0);
    random_burst(64);
    set_regs(11'd1, 1'b1);
    random_burst(64);
    set_regs(11'($urandom_range(9, 40)), 1'b0);
    squeeze = 1'b1;
    random_burst(64);
    set_regs(11'd0, 1'b1);
    random_burst(64);
    set_regs(11'($urandom_range(2, 8)), 1'($urandom));
    calm = 1'b1;
    random_burst(64);
    drain();
    calm = 1'b0;
    set_regs(11'd1024, 1'b0);
    random_burst(64);
    set_regs(11'd2047, 1'b1);
    random_burst(64);
    set_regs(11'($urandom_range(41, 200)), 1'($urandom));
    random_burst(64);

    // deep pass: full scan that misses, then the very last bit of the range
    set_regs(11'(DEEP_BYTES), 1'b1);
    for (int k = 0; k < DEEP_BYTES; k++) push_item(ACT_LOAD, 10'(k), 8'hFF);
    push_item(ACT_FIND, 10'($urandom), 8'($urandom));
    push_item(ACT_CLAIM, 10'($urandom), 8'($urandom));
    push_item(ACT_LOAD, 10'(DEEP_BYTES - 1), 8'h7F);
    push_item(ACT_CLAIM, 10'($urandom), 8'($urandom));
    push_item(ACT_FIND, 10'($urandom), 8'($urandom));

    drain();
    repeat (20) @(posedge clk);
    if (alloc_sb.expected.size() != 0) begin
      $error("%0d expected results never arrived", alloc_sb.expected.size());
      alloc_sb.errors++;
    end
    if (alloc_sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
